FILE: sv/gwd_pkg.sv
// Shared types, constants and helpers for the grid wavefront distance unit.
`timescale 1ns / 1ps
`default_nettype none
package gwd_pkg;

  localparam int GRID_COLS  = 16;
  localparam int GRID_ROWS  = 16;
  localparam int CELL_COUNT = GRID_COLS * GRID_ROWS;
  localparam int COL_W      = $clog2(GRID_COLS);
  localparam int ROW_W      = $clog2(GRID_ROWS);
  localparam int IDX_W      = ROW_W + COL_W;
  localparam int CNT_W      = IDX_W + 1;
  localparam int DIST_W     = 10;
  localparam int QDIST_W    = 8;
  localparam int Q_W        = IDX_W + QDIST_W;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CELL_COUNT - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GRID_ROWS - 1);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(GRID_COLS - 1);

  localparam logic [DIST_W-1:0] DIST_UNREACHED = 10'd1023;
  localparam logic [DIST_W-1:0] DIST_BLOCKED   = 10'd1022;
  localparam logic [DIST_W-1:0] DIST_LIMIT     = 10'd1021;
  localparam logic [DIST_W-1:0] DIST_OUT_MAX   = 10'd255;

  localparam logic REQ_PLACE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  localparam logic [2:0] STS_OK          = 3'd0;
  localparam logic [2:0] STS_MISSING     = 3'd1;
  localparam logic [2:0] STS_NO_PATH     = 3'd2;
  localparam logic [2:0] STS_BLOCKED     = 3'd3;
  localparam logic [2:0] STS_UNREACHED   = 3'd4;

  localparam logic [1:0] OFF_NEG  = 2'd0;
  localparam logic [1:0] OFF_ZERO = 2'd1;
  localparam logic [1:0] OFF_POS  = 2'd2;

  typedef enum logic [1:0] {
    KIND_EMPTY = 2'd0,
    KIND_BLOCK = 2'd1,
    KIND_START = 2'd2,
    KIND_END   = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PLACE_OLD,
    S_PLACE_NEW,
    S_INIT,
    S_POP,
    S_NB_READ,
    S_NB_CHECK,
    S_FIN_READ,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic clr_step;
    logic capture;
    logic place_old;
    logic place_new;
    logic init_step;
    logic pop;
    logic nb_read;
    logic nb_check;
    logic nb_next;
    logic fin_read;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic in_is_read;
    logic both_next;
    logic init_done;
    logic q_empty;
    logic nb_valid;
    logic nb_last;
    logic out_free;
  } sts_t;

  // Row and column offset codes of the eight neighbours.
  function automatic logic [3:0] nb_offset(input logic [2:0] nb);
    logic [3:0] off;
    unique case (nb)
      3'd0:    off = {OFF_NEG,  OFF_NEG};
      3'd1:    off = {OFF_NEG,  OFF_ZERO};
      3'd2:    off = {OFF_NEG,  OFF_POS};
      3'd3:    off = {OFF_ZERO, OFF_NEG};
      3'd4:    off = {OFF_ZERO, OFF_POS};
      3'd5:    off = {OFF_POS,  OFF_NEG};
      3'd6:    off = {OFF_POS,  OFF_ZERO};
      default: off = {OFF_POS,  OFF_POS};
    endcase
    return off;
  endfunction

endpackage
`default_nettype wire

FILE: sv/gwd_ctrl.sv
// Sequencer for placement, wavefront solve and cell reads.
`timescale 1ns / 1ps
`default_nettype none
module gwd_ctrl
  import gwd_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = sts_i.in_is_read ? S_FIN_READ : S_PLACE_OLD;
        end
      end
      S_PLACE_OLD: begin
        cmd_o.place_old = 1'b1;
        state_d = S_PLACE_NEW;
      end
      S_PLACE_NEW: begin
        cmd_o.place_new = 1'b1;
        state_d = sts_i.both_next ? S_INIT : S_RESULT;
      end
      S_INIT: begin
        cmd_o.init_step = 1'b1;
        if (sts_i.init_done) state_d = S_POP;
      end
      S_POP: begin
        if (sts_i.q_empty) begin
          state_d = S_FIN_READ;
        end else begin
          cmd_o.pop = 1'b1;
          state_d = S_NB_READ;
        end
      end
      S_NB_READ: begin
        if (sts_i.nb_valid) begin
          cmd_o.nb_read = 1'b1;
          state_d = S_NB_CHECK;
        end else begin
          cmd_o.nb_next = 1'b1;
          if (sts_i.nb_last) state_d = S_POP;
        end
      end
      S_NB_CHECK: begin
        cmd_o.nb_check = 1'b1;
        cmd_o.nb_next  = 1'b1;
        state_d = sts_i.nb_last ? S_POP : S_NB_READ;
      end
      S_FIN_READ: begin
        cmd_o.fin_read = 1'b1;
        state_d = S_RESULT;
      end
      S_RESULT: begin
        // hold until the output register is free
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/gwd_datapath.sv
// Grid memories, breadth-first queue, position registers and result register.
`timescale 1ns / 1ps
`default_nettype none
module gwd_datapath
  import gwd_pkg::*;
(
  input  wire              clk_i,
  input  wire              rst_ni,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  input  wire              req_type_i,
  input  wire  [COL_W-1:0] cell_col_i,
  input  wire  [ROW_W-1:0] cell_row_i,
  input  wire  [1:0]       cell_kind_i,
  output logic             out_valid_o,
  input  wire              out_stall_i,
  output logic [2:0]       status_o,
  output logic [7:0]       distance_o
);

  logic [1:0]        kind_mem  [CELL_COUNT];
  logic [DIST_W-1:0] dist_mem  [CELL_COUNT];
  logic [Q_W-1:0]    queue_mem [CELL_COUNT];

  logic [1:0]        kind_rd_q;
  logic [DIST_W-1:0] dist_rd_q;
  logic [Q_W-1:0]    q_rd_q;

  logic              req_type_q;
  logic [IDX_W-1:0]  idx_q;
  logic [1:0]        kind_q;
  logic              miss_q;

  logic              start_valid_q, start_valid_d;
  logic [IDX_W-1:0]  start_pos_q, start_pos_d;
  logic              end_valid_q, end_valid_d;
  logic [IDX_W-1:0]  end_pos_q, end_pos_d;

  logic [CNT_W-1:0]  cnt_q;
  logic [IDX_W-1:0]  init_wa_q;
  logic [CNT_W-1:0]  head_q, tail_q;
  logic [2:0]        nb_q;

  logic              out_valid_q;
  logic [2:0]        status_q;
  logic [7:0]        distance_q;

  // neighbour of the popped cell
  logic [IDX_W-1:0]   cur_idx;
  logic [QDIST_W-1:0] cur_dist;
  logic [DIST_W-1:0]  next_dist;
  logic [ROW_W-1:0]   cur_row, nb_row;
  logic [COL_W-1:0]   cur_col, nb_col;
  logic [3:0]         off;
  logic               nb_ok;
  logic [IDX_W-1:0]   nb_idx;

  assign cur_idx   = q_rd_q[Q_W-1:QDIST_W];
  assign cur_dist  = q_rd_q[QDIST_W-1:0];
  assign next_dist = DIST_W'(cur_dist) + DIST_W'(1);
  assign cur_row   = cur_idx[IDX_W-1:COL_W];
  assign cur_col   = cur_idx[COL_W-1:0];
  assign off       = nb_offset(nb_q);

  always_comb begin
    nb_row = cur_row;
    nb_col = cur_col;
    if (off[3:2] == OFF_NEG) nb_row = cur_row - ROW_W'(1);
    if (off[3:2] == OFF_POS) nb_row = cur_row + ROW_W'(1);
    if (off[1:0] == OFF_NEG) nb_col = cur_col - COL_W'(1);
    if (off[1:0] == OFF_POS) nb_col = cur_col + COL_W'(1);
    nb_ok = !((off[3:2] == OFF_NEG) && (cur_row == '0)) &&
            !((off[3:2] == OFF_POS) && (cur_row == ROW_LAST)) &&
            !((off[1:0] == OFF_NEG) && (cur_col == '0)) &&
            !((off[1:0] == OFF_POS) && (cur_col == COL_LAST));
  end
  assign nb_idx = {nb_row, nb_col};

  // start / end bookkeeping of a placement
  always_comb begin
    start_valid_d = start_valid_q && (start_pos_q != idx_q);
    start_pos_d   = start_pos_q;
    end_valid_d   = end_valid_q && (end_pos_q != idx_q);
    end_pos_d     = end_pos_q;
    if (kind_q == KIND_START) begin
      start_valid_d = 1'b1;
      start_pos_d   = idx_q;
    end
    if (kind_q == KIND_END) begin
      end_valid_d = 1'b1;
      end_pos_d   = idx_q;
    end
  end

  // kind memory port
  logic              kind_we;
  logic [IDX_W-1:0]  kind_wa;
  logic [1:0]        kind_wd;
  always_comb begin
    kind_we = 1'b0;
    kind_wa = cnt_q[IDX_W-1:0];
    kind_wd = KIND_EMPTY;
    if (cmd_i.clr_step) begin
      kind_we = 1'b1;
      if (cnt_q[IDX_W-1:0] == '0)     kind_wd = KIND_START;
      if (cnt_q[IDX_W-1:0] == IDX_LAST) kind_wd = KIND_END;
    end else if (cmd_i.place_old) begin
      if (kind_q == KIND_START && start_valid_q) begin
        kind_we = 1'b1;
        kind_wa = start_pos_q;
      end else if (kind_q == KIND_END && end_valid_q) begin
        kind_we = 1'b1;
        kind_wa = end_pos_q;
      end
    end else if (cmd_i.place_new) begin
      kind_we = 1'b1;
      kind_wa = idx_q;
      kind_wd = kind_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (kind_we) kind_mem[kind_wa] <= kind_wd;
    if (cmd_i.init_step && !cnt_q[IDX_W]) kind_rd_q <= kind_mem[cnt_q[IDX_W-1:0]];
  end

  // distance memory port
  logic              dist_we, dist_re;
  logic [IDX_W-1:0]  dist_wa, dist_ra;
  logic [DIST_W-1:0] dist_wd;
  always_comb begin
    dist_we = 1'b0;
    dist_wa = cnt_q[IDX_W-1:0];
    dist_wd = DIST_UNREACHED;
    if (cmd_i.clr_step) begin
      dist_we = 1'b1;
    end else if (cmd_i.init_step && cnt_q != '0) begin
      dist_we = 1'b1;
      dist_wa = init_wa_q;
      if (kind_rd_q == KIND_BLOCK)     dist_wd = DIST_BLOCKED;
      else if (init_wa_q == start_pos_q) dist_wd = '0;
    end else if (cmd_i.nb_check && dist_rd_q == DIST_UNREACHED) begin
      dist_we = 1'b1;
      dist_wa = nb_idx;
      dist_wd = next_dist;
    end
    dist_re = cmd_i.nb_read || cmd_i.fin_read;
    dist_ra = nb_idx;
    if (cmd_i.fin_read) dist_ra = (req_type_q == REQ_READ) ? idx_q : end_pos_q;
  end

  always_ff @(posedge clk_i) begin
    if (dist_we) dist_mem[dist_wa] <= dist_wd;
    if (dist_re) dist_rd_q <= dist_mem[dist_ra];
  end

  // queue port: seed with the start, push newly reached neighbours
  logic           q_we;
  logic [Q_W-1:0] q_wd;
  always_comb begin
    q_we = 1'b0;
    q_wd = {start_pos_q, QDIST_W'(0)};
    if (cmd_i.init_step && cnt_q == '0) begin
      q_we = 1'b1;
    end else if (cmd_i.nb_check && dist_rd_q == DIST_UNREACHED) begin
      q_we = 1'b1;
      q_wd = {nb_idx, next_dist[QDIST_W-1:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_we) queue_mem[tail_q[IDX_W-1:0]] <= q_wd;
    if (cmd_i.pop) q_rd_q <= queue_mem[head_q[IDX_W-1:0]];
  end

  // request capture and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_type_q <= req_type_i;
      idx_q      <= {cell_row_i, cell_col_i};
      kind_q     <= cell_kind_i;
      miss_q     <= 1'b0;
    end
    if (cmd_i.place_new) miss_q <= !(start_valid_d && end_valid_d);
    if (cmd_i.init_step && !cnt_q[IDX_W]) init_wa_q <= cnt_q[IDX_W-1:0];
  end

  logic [2:0] res_status;
  logic [7:0] res_dist;
  always_comb begin
    res_status = STS_OK;
    res_dist   = (dist_rd_q > DIST_OUT_MAX) ? 8'hFF : dist_rd_q[7:0];
    if (miss_q) begin
      res_status = STS_MISSING;
    end else if (req_type_q == REQ_READ) begin
      if (dist_rd_q == DIST_BLOCKED)        res_status = STS_BLOCKED;
      else if (dist_rd_q == DIST_UNREACHED) res_status = STS_UNREACHED;
    end else if (dist_rd_q > DIST_LIMIT) begin
      res_status = STS_NO_PATH;
    end
    if (res_status != STS_OK) res_dist = '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      status_q   <= res_status;
      distance_q <= res_dist;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_valid_q <= 1'b1;
      start_pos_q   <= '0;
      end_valid_q   <= 1'b1;
      end_pos_q     <= IDX_LAST;
      cnt_q         <= '0;
      head_q        <= '0;
      tail_q        <= '0;
      nb_q          <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.place_new) begin
        start_valid_q <= start_valid_d;
        start_pos_q   <= start_pos_d;
        end_valid_q   <= end_valid_d;
        end_pos_q     <= end_pos_d;
      end
      if (cmd_i.capture) begin
        cnt_q  <= '0;
        head_q <= '0;
        tail_q <= '0;
      end else begin
        if (cmd_i.clr_step || cmd_i.init_step) cnt_q <= cnt_q + CNT_W'(1);
        if (q_we) tail_q <= tail_q + CNT_W'(1);
      end
      if (cmd_i.pop) begin
        head_q <= head_q + CNT_W'(1);
        nb_q   <= '0;
      end else if (cmd_i.nb_next) begin
        nb_q <= nb_q + 3'd1;
      end
      if (cmd_i.load_out)  out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign sts_o.clr_done   = cnt_q[IDX_W-1:0] == IDX_LAST;
  assign sts_o.in_is_read = req_type_i == REQ_READ;
  assign sts_o.both_next  = start_valid_d && end_valid_d;
  assign sts_o.init_done  = cnt_q[IDX_W];
  assign sts_o.q_empty    = head_q == tail_q;
  assign sts_o.nb_valid   = nb_ok;
  assign sts_o.nb_last    = nb_q == 3'd7;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign distance_o  = distance_q;

endmodule
`default_nettype wire

FILE: sv/grid_wavefront_distance_unit.sv
// Top level of the grid wavefront distance unit.
//
// Input channel (in_valid_i / in_stall_o) takes one request beat: a place
// request writes a cell kind and, if start and end are both placed,
// re-solves distances from the start; a read request returns one cell's
// stored distance. Every request yields exactly one result beat on the
// output channel (out_valid_o / out_stall_i). One request is worked on at
// a time; in_stall_o is low only while idle. Read request: the distance is
// read into a register in FIN_READ and loaded into the output register in
// RESULT once it is free. Place with start or end missing: PLACE_OLD,
// PLACE_NEW, then RESULT with no solve. Place with solve: an initialization
// sweep writes every cell's distance, then for each queued cell the
// distance of each in-grid neighbour is read and, if unreached, written
// and the neighbour queued. After reset the block sweeps its grid (empty
// cells, start in the first corner, end in the last, all distances unreached)
// with in_stall_o high. A stalled result holds in the output register; the
// block then finishes the next request and waits until that register frees.
`timescale 1ns / 1ps
`default_nettype none
module grid_wavefront_distance_unit
  import gwd_pkg::*;
(
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_stall_o,
  input  wire             req_type_i,
  input  wire [COL_W-1:0] cell_col_i,
  input  wire [ROW_W-1:0] cell_row_i,
  input  wire [1:0]       cell_kind_i,
  output logic            out_valid_o,
  input  wire             out_stall_i,
  output logic [2:0]      status_o,
  output logic [7:0]      distance_o
);

  cmd_t cmd;
  sts_t sts;

  gwd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gwd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_type_i  (req_type_i),
    .cell_col_i  (cell_col_i),
    .cell_row_i  (cell_row_i),
    .cell_kind_i (cell_kind_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .distance_o  (distance_o)
  );

`ifndef SYNTHESIS
  a_err_zero_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STS_OK |-> distance_o == 8'd0)
    else $error("nonzero distance with error status");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second beat accepted while busy");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= STS_UNREACHED)
    else $error("status code out of range");
`endif

endmodule
`default_nettype wire
